[hdl/scc_pkg.sv]
// Shared types and constants of the strongly connected components unit.
package scc_pkg;

  // Fixed field widths of the ports
  localparam int unsigned VTX_W  = 11;
  localparam int unsigned RANK_W = 3;

  // Vertex count after reset
  localparam logic [VTX_W-1:0] NV_RESET = 11'd1024;

  // Micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_IDLE, OP_CLR, OP_CNT_RD, OP_CNT_EW, OP_CNT_WR, OP_PFX_RD, OP_PFX_WR,
    OP_LST_RD, OP_LST_EW, OP_LST_WR, OP_P1_ROOT, OP_P1_RV, OP_LD_A, OP_LD_B,
    OP_LD_C, OP_STEP, OP_POP, OP_EXP, OP_EXP_V, OP_VCLR, OP_P2_ROOT,
    OP_P2_RF, OP_P2_RV, OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic pass2;   // second walk: forward edges
  } cmd_t;

  typedef struct packed {
    logic fin;       // finish word accepted
    logic v_last;    // sweep counter at n+1
    logic v_eq_n;    // sweep counter at n
    logic k_end;     // edge index reached stored count
    logic k_zero;    // edge index at zero
    logic edge_ok;   // edge read back lies inside 1..n
    logic i_zero;    // root scan finished
    logic vis;       // visited bit read back
    logic has_next;  // top of stack has an unscanned edge
    logic sp_one;    // only the root is on the stack
    logic w_new;     // neighbor gets pushed
    logic root_ok;   // finish entry is a valid vertex
    logic out_free;  // output register can take a word
    logic r_last;    // rank of the last report word
  } sts_t;

endpackage

[hdl/scc_if.sv]
// Valid/ready channel interfaces for input and result words.
interface scc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [scc_pkg::VTX_W-1:0]      tail_vertex;
  logic [scc_pkg::VTX_W-1:0]      head_vertex;

  modport source (output valid, func, tail_vertex, head_vertex, input ready);
  modport sink   (input valid, func, tail_vertex, head_vertex, output ready);
endinterface

interface scc_out_if;
  logic                           valid;
  logic                           ready;
  logic [scc_pkg::RANK_W-1:0]     rank;
  logic [scc_pkg::VTX_W-1:0]      component_size;
  logic [scc_pkg::VTX_W-1:0]      component_count;
  logic                           edges_dropped;
  logic                           last;

  modport source (output valid, rank, component_size, component_count, edges_dropped, last,
                  input ready);
  modport sink   (input valid, rank, component_size, component_count, edges_dropped, last,
                  output ready);
endinterface

[hdl/scc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/scc_dp.sv]
// Datapath: edge store, adjacency tables, walk stack, top sizes, output register.
module scc_dp #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 8192,
  parameter int unsigned TOP_COUNT    = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  scc_in_if.sink                    in_if,
  scc_out_if.source                 out_if,
  input  logic                      cfg_we_i,
  input  logic [scc_pkg::VTX_W-1:0] cfg_data_i,
  input  scc_pkg::cmd_t             cmd_i,
  output scc_pkg::sts_t             sts_o
);

  localparam int unsigned VW   = $clog2(MAX_VERTICES + 2);
  localparam int unsigned EW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned SW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned RW   = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int unsigned SD   = MAX_VERTICES + 2;
  localparam int unsigned VD   = MAX_VERTICES + 1;
  localparam int unsigned EAW  = $clog2(MAX_EDGES);
  localparam int unsigned VAW  = $clog2(VD);
  localparam int unsigned KAW  = $clog2(MAX_VERTICES);
  localparam int unsigned STW  = VW + 2 * EW;

  scc_pkg::op_e op;
  logic         p2;
  assign op = cmd_i.op;
  assign p2 = cmd_i.pass2;

  // Registers
  logic [scc_pkg::VTX_W-1:0] nv_q;
  logic [EW-1:0] stored_q, k_q, fsum_q, rsum_q, a_q, cur_q, lim_q;
  logic          ovf_q;
  logic [VW-1:0] v_q, es_q, et_q, i_q, t_q, w_q, top_v_q, size_q, cnt_q;
  logic [SW-1:0] sp_q;
  logic [VW-1:0] top_q [TOP_COUNT];
  logic [RW-1:0] r_q;
  logic                       ov_q, o_drop_q, o_last_q;
  logic [scc_pkg::RANK_W-1:0] o_rank_q;
  logic [scc_pkg::VTX_W-1:0]  o_size_q, o_cnt_q;

  // Effective vertex count
  logic [VW-1:0] n, n_p1;
  assign n    = (32'(nv_q) > MAX_VERTICES) ? VW'(MAX_VERTICES) : VW'(nv_q);
  assign n_p1 = n + 1'b1;

  // Incoming edge check
  logic in_fire, in_ok;
  assign in_fire = in_if.valid & in_if.ready;
  assign in_ok   = (in_if.tail_vertex != '0) && (32'(in_if.tail_vertex) <= 32'(n)) &&
                   (in_if.head_vertex != '0) && (32'(in_if.head_vertex) <= 32'(n));
  assign in_if.ready = (op == scc_pkg::OP_IDLE);

  // Edge store
  logic            e_we;
  logic [2*VW-1:0] e_rd;
  logic [EAW-1:0]  e_raddr;
  logic [VW-1:0]   e_src, e_tgt;
  assign e_we    = in_fire & ~in_if.func & in_ok & (32'(stored_q) < MAX_EDGES);
  assign e_raddr = (op == scc_pkg::OP_LST_RD) ? EAW'(k_q - 1'b1) : EAW'(k_q);
  assign e_src   = e_rd[2*VW-1:VW];
  assign e_tgt   = e_rd[VW-1:0];

  scc_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(EAW'(stored_q)),
    .wdata_i({VW'(in_if.tail_vertex), VW'(in_if.head_vertex)}),
    .raddr_i(e_raddr), .rdata_o(e_rd)
  );

  // Segment start tables
  logic          f_we, r_we;
  logic [VW-1:0] f_waddr, r_waddr, f_raddr, r_raddr;
  logic [EW-1:0] f_wdata, r_wdata, f_rd, r_rd, s_rd, f_dec, r_dec;
  assign f_dec = f_rd - 1'b1;
  assign r_dec = r_rd - 1'b1;
  assign s_rd  = p2 ? f_rd : r_rd;

  always_comb begin
    f_we = 1'b0; r_we = 1'b0;
    f_waddr = v_q; r_waddr = v_q;
    f_wdata = '0;  r_wdata = '0;
    f_raddr = v_q; r_raddr = v_q;
    case (op)
      scc_pkg::OP_CLR: begin
        f_we = 1'b1; r_we = 1'b1;
      end
      scc_pkg::OP_CNT_EW, scc_pkg::OP_LST_EW: begin
        f_raddr = e_src; r_raddr = e_tgt;
      end
      scc_pkg::OP_CNT_WR: begin
        f_we = 1'b1; r_we = 1'b1;
        f_waddr = es_q; r_waddr = et_q;
        f_wdata = f_rd + 1'b1; r_wdata = r_rd + 1'b1;
      end
      scc_pkg::OP_PFX_WR: begin
        f_we = 1'b1; r_we = 1'b1;
        f_wdata = fsum_q + f_rd; r_wdata = rsum_q + r_rd;
      end
      scc_pkg::OP_LST_WR: begin
        f_we = 1'b1; r_we = 1'b1;
        f_waddr = es_q; r_waddr = et_q;
        f_wdata = f_dec; r_wdata = r_dec;
      end
      scc_pkg::OP_LD_A: begin
        f_raddr = w_q; r_raddr = w_q;
      end
      scc_pkg::OP_LD_B: begin
        f_raddr = w_q + 1'b1; r_raddr = w_q + 1'b1;
      end
      default: ;
    endcase
  end

  scc_ram #(.WIDTH(EW), .DEPTH(SD)) u_fstart (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rd)
  );
  scc_ram #(.WIDTH(EW), .DEPTH(SD)) u_rstart (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(r_rd)
  );

  // Adjacency lists
  logic          l_we;
  logic [VW-1:0] fl_rd, rl_rd, l_rd;
  assign l_we = (op == scc_pkg::OP_LST_WR);
  assign l_rd = p2 ? fl_rd : rl_rd;

  scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_flist (
    .clk_i, .we_i(l_we), .waddr_i(EAW'(f_dec)), .wdata_i(et_q),
    .raddr_i(EAW'(cur_q)), .rdata_o(fl_rd)
  );
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_rlist (
    .clk_i, .we_i(l_we), .waddr_i(EAW'(r_dec)), .wdata_i(es_q),
    .raddr_i(EAW'(cur_q - 1'b1)), .rdata_o(rl_rd)
  );

  // Finish order
  logic          fo_we, has_next;
  logic [VW-1:0] fo_rd;
  assign has_next = p2 ? (cur_q < lim_q) : (cur_q > lim_q);
  assign fo_we    = (op == scc_pkg::OP_STEP) & ~has_next & ~p2;

  scc_ram #(.WIDTH(VW), .DEPTH(VD)) u_finish (
    .clk_i, .we_i(fo_we), .waddr_i(VAW'(t_q + 1'b1)), .wdata_i(top_v_q),
    .raddr_i(VAW'(i_q)), .rdata_o(fo_rd)
  );

  // Visited bits
  logic          vi_we, vi_wdata, vi_rd, w_new, root_ok;
  logic [VW-1:0] vi_waddr, vi_raddr;
  assign w_new   = ~vi_rd & (32'(sp_q) < MAX_VERTICES);
  assign root_ok = (fo_rd != '0) && (fo_rd <= n);

  always_comb begin
    vi_we = 1'b0; vi_wdata = 1'b1; vi_waddr = w_q; vi_raddr = i_q;
    case (op)
      scc_pkg::OP_CLR: begin
        vi_we = (v_q <= n); vi_wdata = 1'b0; vi_waddr = v_q;
      end
      scc_pkg::OP_VCLR: begin
        vi_we = 1'b1; vi_wdata = 1'b0; vi_waddr = v_q;
      end
      scc_pkg::OP_P1_RV: begin
        vi_we = ~vi_rd; vi_waddr = i_q;
      end
      scc_pkg::OP_EXP:    vi_raddr = l_rd;
      scc_pkg::OP_EXP_V:  vi_we = w_new;
      scc_pkg::OP_P2_RF:  vi_raddr = fo_rd;
      scc_pkg::OP_P2_RV:  vi_we = ~vi_rd;
      default: ;
    endcase
  end

  scc_ram #(.WIDTH(1), .DEPTH(VD)) u_visited (
    .clk_i, .we_i(vi_we), .waddr_i(VAW'(vi_waddr)), .wdata_i(vi_wdata),
    .raddr_i(VAW'(vi_raddr)), .rdata_o(vi_rd)
  );

  // Walk stack below the top entry
  logic           st_we;
  logic [STW-1:0] st_rd;
  assign st_we = (op == scc_pkg::OP_LD_C) & (sp_q != '0);

  scc_ram #(.WIDTH(STW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(KAW'(sp_q - 1'b1)), .wdata_i({top_v_q, cur_q, lim_q}),
    .raddr_i(KAW'(sp_q - 2'd2)), .rdata_o(st_rd)
  );

  // Sorted insertion of a finished component size
  logic          gt  [TOP_COUNT];
  logic [VW-1:0] ins [TOP_COUNT];
  always_comb begin
    for (int r = 0; r < TOP_COUNT; r++) begin
      gt[r] = size_q > top_q[r];
    end
    ins[0] = gt[0] ? size_q : top_q[0];
    for (int r = 1; r < TOP_COUNT; r++) begin
      ins[r] = gt[r] ? (gt[r-1] ? top_q[r-1] : size_q) : top_q[r];
    end
  end

  // Output word leaves this cycle and no new one is loaded
  logic ov_clr;
  assign ov_clr = ov_q & out_if.ready & ~((op == scc_pkg::OP_OUT) & sts_o.out_free);

  // Sequential datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= scc_pkg::NV_RESET;
      stored_q <= '0; ovf_q <= 1'b0; k_q <= '0; fsum_q <= '0; rsum_q <= '0;
      a_q <= '0; cur_q <= '0; lim_q <= '0;
      v_q <= '0; es_q <= '0; et_q <= '0; i_q <= '0; t_q <= '0; w_q <= '0;
      top_v_q <= '0; size_q <= '0; cnt_q <= '0; sp_q <= '0; r_q <= '0;
      for (int r = 0; r < TOP_COUNT; r++) top_q[r] <= '0;
      ov_q <= 1'b0; o_rank_q <= '0; o_size_q <= '0; o_cnt_q <= '0;
      o_drop_q <= 1'b0; o_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) nv_q <= cfg_data_i;
      if (ov_clr) ov_q <= 1'b0;
      case (op)
        scc_pkg::OP_IDLE: begin
          if (in_fire && !in_if.func && in_ok) begin
            if (e_we) stored_q <= stored_q + 1'b1;
            else      ovf_q    <= 1'b1;
          end
          if (in_fire && in_if.func) begin
            v_q <= '0; k_q <= '0;
            for (int r = 0; r < TOP_COUNT; r++) top_q[r] <= '0;
          end
        end
        scc_pkg::OP_CLR: begin
          fsum_q <= '0; rsum_q <= '0;
          v_q <= (v_q == n_p1) ? VW'(1) : v_q + 1'b1;
        end
        scc_pkg::OP_CNT_EW: begin
          es_q <= e_src; et_q <= e_tgt;
          if (!sts_o.edge_ok) k_q <= k_q + 1'b1;
        end
        scc_pkg::OP_CNT_WR: k_q <= k_q + 1'b1;
        scc_pkg::OP_PFX_WR: begin
          fsum_q <= f_wdata; rsum_q <= r_wdata;
          if (v_q == n_p1) k_q <= stored_q;
          else             v_q <= v_q + 1'b1;
        end
        scc_pkg::OP_LST_RD: begin
          if (k_q == '0) begin
            i_q <= n; t_q <= '0; sp_q <= '0;
          end
        end
        scc_pkg::OP_LST_EW: begin
          es_q <= e_src; et_q <= e_tgt;
          if (!sts_o.edge_ok) k_q <= k_q - 1'b1;
        end
        scc_pkg::OP_LST_WR: k_q <= k_q - 1'b1;
        scc_pkg::OP_P1_ROOT: if (i_q == '0) v_q <= '0;
        scc_pkg::OP_P1_RV: begin
          if (vi_rd) i_q <= i_q - 1'b1;
          else       w_q <= i_q;
        end
        scc_pkg::OP_LD_B: a_q <= s_rd;
        scc_pkg::OP_LD_C: begin
          top_v_q <= w_q;
          cur_q   <= p2 ? a_q : s_rd;
          lim_q   <= p2 ? s_rd : a_q;
          sp_q    <= (sp_q == '0) ? SW'(1) : sp_q + 1'b1;
        end
        scc_pkg::OP_STEP: begin
          if (has_next) begin
            cur_q <= p2 ? cur_q + 1'b1 : cur_q - 1'b1;
          end else begin
            if (!p2) t_q <= t_q + 1'b1;
            sp_q <= sp_q - 1'b1;
            if (sp_q == SW'(1)) begin
              i_q <= i_q - 1'b1;
              if (p2) begin
                for (int r = 0; r < TOP_COUNT; r++) top_q[r] <= ins[r];
              end
            end
          end
        end
        scc_pkg::OP_POP: {top_v_q, cur_q, lim_q} <= st_rd;
        scc_pkg::OP_EXP: w_q <= l_rd;
        scc_pkg::OP_EXP_V: if (w_new) size_q <= size_q + 1'b1;
        scc_pkg::OP_VCLR: begin
          v_q <= v_q + 1'b1;
          if (v_q == n) begin
            i_q <= n; cnt_q <= '0;
          end
        end
        scc_pkg::OP_P2_ROOT: if (i_q == '0) r_q <= '0;
        scc_pkg::OP_P2_RF: begin
          w_q <= fo_rd;
          if (!root_ok) i_q <= i_q - 1'b1;
        end
        scc_pkg::OP_P2_RV: begin
          if (vi_rd) i_q <= i_q - 1'b1;
          else begin
            cnt_q <= cnt_q + 1'b1; size_q <= VW'(1);
          end
        end
        scc_pkg::OP_OUT: begin
          if (sts_o.out_free) begin
            ov_q     <= 1'b1;
            o_rank_q <= scc_pkg::RANK_W'(r_q);
            o_size_q <= scc_pkg::VTX_W'(top_q[r_q]);
            o_cnt_q  <= scc_pkg::VTX_W'(cnt_q);
            o_drop_q <= ovf_q;
            o_last_q <= sts_o.r_last;
            r_q      <= r_q + 1'b1;
            if (sts_o.r_last) begin
              stored_q <= '0; ovf_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.fin      = in_fire & in_if.func;
    sts_o.v_last   = (v_q == n_p1);
    sts_o.v_eq_n   = (v_q == n);
    sts_o.k_end    = (k_q == stored_q);
    sts_o.k_zero   = (k_q == '0);
    sts_o.edge_ok  = (e_src != '0) && (e_src <= n) && (e_tgt != '0) && (e_tgt <= n);
    sts_o.i_zero   = (i_q == '0);
    sts_o.vis      = vi_rd;
    sts_o.has_next = has_next;
    sts_o.sp_one   = (sp_q == SW'(1));
    sts_o.w_new    = w_new;
    sts_o.root_ok  = root_ok;
    sts_o.out_free = ~ov_q | out_if.ready;
    sts_o.r_last   = (r_q == RW'(TOP_COUNT - 1));
  end

  assign out_if.valid           = ov_q;
  assign out_if.rank            = o_rank_q;
  assign out_if.component_size  = o_size_q;
  assign out_if.component_count = o_cnt_q;
  assign out_if.edges_dropped   = o_drop_q;
  assign out_if.last            = o_last_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= MAX_VERTICES) else $error("walk stack overrun");
  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(stored_q) <= MAX_EDGES) else $error("edge store count overrun");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(op) == scc_pkg::OP_OUT) else $error("word loaded outside report");

endmodule

[hdl/scc_ctrl.sv]
// Controller: sequences table build, the two walks and the report.
module scc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scc_pkg::sts_t sts_i,
  output scc_pkg::cmd_t cmd_o
);

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001, S_CLR     = 24'h000002, S_CNT_RD  = 24'h000004,
    S_CNT_EW  = 24'h000008, S_CNT_WR  = 24'h000010, S_PFX_RD  = 24'h000020,
    S_PFX_WR  = 24'h000040, S_LST_RD  = 24'h000080, S_LST_EW  = 24'h000100,
    S_LST_WR  = 24'h000200, S_P1_ROOT = 24'h000400, S_P1_RV   = 24'h000800,
    S_LD_A    = 24'h001000, S_LD_B    = 24'h002000, S_LD_C    = 24'h004000,
    S_STEP    = 24'h008000, S_POP     = 24'h010000, S_EXP     = 24'h020000,
    S_EXP_V   = 24'h040000, S_VCLR    = 24'h080000, S_P2_ROOT = 24'h100000,
    S_P2_RF   = 24'h200000, S_P2_RV   = 24'h400000, S_OUT     = 24'h800000
  } state_e;

  state_e state_q, state_d;
  logic   pass2_q, pass2_d;

  // Next state
  always_comb begin
    state_d = state_q;
    pass2_d = pass2_q;
    case (state_q)
      S_IDLE: begin
        pass2_d = 1'b0;
        if (sts_i.fin) state_d = S_CLR;
      end
      S_CLR:     if (sts_i.v_last) state_d = S_CNT_RD;
      S_CNT_RD:  state_d = sts_i.k_end ? S_PFX_RD : S_CNT_EW;
      S_CNT_EW:  state_d = sts_i.edge_ok ? S_CNT_WR : S_CNT_RD;
      S_CNT_WR:  state_d = S_CNT_RD;
      S_PFX_RD:  state_d = S_PFX_WR;
      S_PFX_WR:  state_d = sts_i.v_last ? S_LST_RD : S_PFX_RD;
      S_LST_RD:  state_d = sts_i.k_zero ? S_P1_ROOT : S_LST_EW;
      S_LST_EW:  state_d = sts_i.edge_ok ? S_LST_WR : S_LST_RD;
      S_LST_WR:  state_d = S_LST_RD;
      S_P1_ROOT: state_d = sts_i.i_zero ? S_VCLR : S_P1_RV;
      S_P1_RV:   state_d = sts_i.vis ? S_P1_ROOT : S_LD_A;
      S_LD_A:    state_d = S_LD_B;
      S_LD_B:    state_d = S_LD_C;
      S_LD_C:    state_d = S_STEP;
      S_STEP: begin
        if (sts_i.has_next)    state_d = S_EXP;
        else if (sts_i.sp_one) state_d = pass2_q ? S_P2_ROOT : S_P1_ROOT;
        else                   state_d = S_POP;
      end
      S_POP:     state_d = S_STEP;
      S_EXP:     state_d = S_EXP_V;
      S_EXP_V:   state_d = sts_i.w_new ? S_LD_A : S_STEP;
      S_VCLR: begin
        pass2_d = 1'b1;
        if (sts_i.v_eq_n) state_d = S_P2_ROOT;
      end
      S_P2_ROOT: state_d = sts_i.i_zero ? S_OUT : S_P2_RF;
      S_P2_RF:   state_d = sts_i.root_ok ? S_P2_RV : S_P2_ROOT;
      S_P2_RV:   state_d = sts_i.vis ? S_P2_ROOT : S_LD_A;
      S_OUT:     if (sts_i.out_free && sts_i.r_last) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass2_q <= pass2_d;
    end
  end

  // Command decode
  always_comb begin
    cmd_o.pass2 = pass2_q;
    case (state_q)
      S_IDLE:    cmd_o.op = scc_pkg::OP_IDLE;
      S_CLR:     cmd_o.op = scc_pkg::OP_CLR;
      S_CNT_RD:  cmd_o.op = scc_pkg::OP_CNT_RD;
      S_CNT_EW:  cmd_o.op = scc_pkg::OP_CNT_EW;
      S_CNT_WR:  cmd_o.op = scc_pkg::OP_CNT_WR;
      S_PFX_RD:  cmd_o.op = scc_pkg::OP_PFX_RD;
      S_PFX_WR:  cmd_o.op = scc_pkg::OP_PFX_WR;
      S_LST_RD:  cmd_o.op = scc_pkg::OP_LST_RD;
      S_LST_EW:  cmd_o.op = scc_pkg::OP_LST_EW;
      S_LST_WR:  cmd_o.op = scc_pkg::OP_LST_WR;
      S_P1_ROOT: cmd_o.op = scc_pkg::OP_P1_ROOT;
      S_P1_RV:   cmd_o.op = scc_pkg::OP_P1_RV;
      S_LD_A:    cmd_o.op = scc_pkg::OP_LD_A;
      S_LD_B:    cmd_o.op = scc_pkg::OP_LD_B;
      S_LD_C:    cmd_o.op = scc_pkg::OP_LD_C;
      S_STEP:    cmd_o.op = scc_pkg::OP_STEP;
      S_POP:     cmd_o.op = scc_pkg::OP_POP;
      S_EXP:     cmd_o.op = scc_pkg::OP_EXP;
      S_EXP_V:   cmd_o.op = scc_pkg::OP_EXP_V;
      S_VCLR:    cmd_o.op = scc_pkg::OP_VCLR;
      S_P2_ROOT: cmd_o.op = scc_pkg::OP_P2_ROOT;
      S_P2_RF:   cmd_o.op = scc_pkg::OP_P2_RF;
      S_P2_RV:   cmd_o.op = scc_pkg::OP_P2_RV;
      S_OUT:     cmd_o.op = scc_pkg::OP_OUT;
      default:   cmd_o.op = scc_pkg::OP_IDLE;
    endcase
  end

  a_idle_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> !pass2_q) else $error("pass flag left set in idle");
  a_fin_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && sts_i.fin) |=> state_q == S_CLR) else $error("finish word lost");
  a_out_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && sts_i.out_free && sts_i.r_last) |=> state_q == S_IDLE)
    else $error("report did not end");

endmodule

[hdl/strongly_connected_components_unit.sv]
// Top level of the strongly connected components unit.
// Edge words (func 0) are taken one per clock cycle while the unit is idle and
// stored; edges with an endpoint outside 1..num_vertices are ignored, edges beyond
// MAX_EDGES are dropped and flagged. A finish word (func 1) runs two depth-first
// walks (reversed, then forward edges) and returns TOP_COUNT result words, largest
// component first, each with the component count; the edge store is then empty.
// While a finish word is worked on, the input is not ready; the work is paced by
// the single-read-port start, list, visited and stack memories.
module strongly_connected_components_unit #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 8192,
  parameter int unsigned TOP_COUNT    = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  scc_in_if.sink                    in_if,
  scc_out_if.source                 out_if,
  input  logic                      cfg_we_i,
  input  logic [scc_pkg::VTX_W-1:0] cfg_data_i
);

  scc_pkg::cmd_t cmd;
  scc_pkg::sts_t sts;

  scc_ctrl u_ctrl (
    .clk_i, .rst_ni, .sts_i(sts), .cmd_o(cmd)
  );

  scc_dp #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .TOP_COUNT(TOP_COUNT)
  ) u_dp (
    .clk_i, .rst_ni, .in_if, .out_if, .cfg_we_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts)
  );

endmodule
